/* rtl/shabsh_pkg.sv */
`default_nettype none

package shabsh_pkg;

   localparam int WORD_W  = 32;
   localparam int NUM_H   = 8;
   localparam int NUM_W   = 16;
   localparam int ROUNDS  = 64;

   localparam logic [5:0] FILL_LAST  = 6'd63;
   localparam logic [5:0] LEN_START  = 6'd56;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [2:0] WORD_LAST  = 3'd7;
   localparam logic [7:0] PAD_BYTE   = 8'h80;

   localparam logic [31:0] H_INIT [NUM_H] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] K_TABLE [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [1:0] {
      SEL_DATA  = 2'd0,
      SEL_PAD80 = 2'd1,
      SEL_ZERO  = 2'd2,
      SEL_LEN   = 2'd3
   } byte_sel_type;

   typedef struct packed {
      logic         push;
      byte_sel_type byte_sel;
      logic         count_byte;
      logic         load_work;
      logic         round_en;
      logic [5:0]   round_idx;
      logic         add_hash;
      logic         restart;
      logic [2:0]   word_idx;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
   } status_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int s);
      rotr = (x >> s) | (x << (32 - s));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                          input logic [31:0] g);
      choose = (e & f) ^ (~e & g);
   endfunction

   function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
      majority = (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

`default_nettype wire

/* rtl/shabsh_dp.sv */
`default_nettype none

module shabsh_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  shabsh_pkg::cmd_type  cmd,
   input  logic [7:0]           data_byte,
   output shabsh_pkg::status_type status,
   output logic [31:0]          digest_word
);

   logic [31:0] hash_ff [shabsh_pkg::NUM_H];
   logic [31:0] hash_in [shabsh_pkg::NUM_H];
   logic [31:0] work_ff [shabsh_pkg::NUM_H];
   logic [31:0] work_in [shabsh_pkg::NUM_H];
   logic [31:0] sched_ff [shabsh_pkg::NUM_W];
   logic [31:0] sched_in [shabsh_pkg::NUM_W];
   logic [23:0] acc_ff;
   logic [23:0] acc_in;
   logic [5:0]  fill_ff;
   logic [5:0]  fill_in;
   logic [63:0] count_ff;
   logic [63:0] count_in;

   logic [63:0] bit_len;
   logic [7:0]  push_byte;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] sched_next;

   assign bit_len = {count_ff[60:0], 3'b000};
   assign status.fill = fill_ff;
   assign digest_word = hash_ff[cmd.word_idx];

   always_comb begin
      unique case (cmd.byte_sel)
         shabsh_pkg::SEL_DATA:  push_byte = data_byte;
         shabsh_pkg::SEL_PAD80: push_byte = shabsh_pkg::PAD_BYTE;
         shabsh_pkg::SEL_ZERO:  push_byte = 8'h00;
         shabsh_pkg::SEL_LEN:   push_byte = bit_len[{3'd7 - fill_ff[2:0], 3'b000} +: 8];
         default:               push_byte = 8'h00;
      endcase
   end

   assign t1 = work_ff[7] + shabsh_pkg::big_sigma1(work_ff[4])
             + shabsh_pkg::choose(work_ff[4], work_ff[5], work_ff[6])
             + shabsh_pkg::K_TABLE[cmd.round_idx] + sched_ff[0];
   assign t2 = shabsh_pkg::big_sigma0(work_ff[0])
             + shabsh_pkg::majority(work_ff[0], work_ff[1], work_ff[2]);
   assign sched_next = shabsh_pkg::small_sigma1(sched_ff[14]) + sched_ff[9]
                     + shabsh_pkg::small_sigma0(sched_ff[1]) + sched_ff[0];

   always_comb begin
      hash_in  = hash_ff;
      work_in  = work_ff;
      sched_in = sched_ff;
      acc_in   = acc_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      if (cmd.push) begin
         acc_in  = {acc_ff[15:0], push_byte};
         fill_in = fill_ff + 6'd1;
         if (fill_ff[1:0] == 2'b11) begin
            for (int i = 0; i < shabsh_pkg::NUM_W - 1; i++) begin
               sched_in[i] = sched_ff[i + 1];
            end
            sched_in[shabsh_pkg::NUM_W - 1] = {acc_ff, push_byte};
         end
      end
      if (cmd.count_byte) begin
         count_in = count_ff + 64'd1;
      end
      if (cmd.load_work) begin
         work_in = hash_ff;
      end
      if (cmd.round_en) begin
         for (int i = 0; i < shabsh_pkg::NUM_W - 1; i++) begin
            sched_in[i] = sched_ff[i + 1];
         end
         sched_in[shabsh_pkg::NUM_W - 1] = sched_next;
         work_in[0] = t1 + t2;
         work_in[1] = work_ff[0];
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3] + t1;
         work_in[5] = work_ff[4];
         work_in[6] = work_ff[5];
         work_in[7] = work_ff[6];
      end
      if (cmd.add_hash) begin
         for (int i = 0; i < shabsh_pkg::NUM_H; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end
      if (cmd.restart) begin
         hash_in  = shabsh_pkg::H_INIT;
         count_in = 64'd0;
         fill_in  = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= shabsh_pkg::H_INIT;
         fill_ff  <= 6'd0;
         count_ff <= 64'd0;
      end else begin
         hash_ff  <= hash_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      sched_ff <= sched_in;
      acc_ff   <= acc_in;
   end

endmodule

`default_nettype wire

/* rtl/shabsh_ctrl.sv */
`default_nettype none

module shabsh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_has_byte,
   input  logic                   req_last,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  shabsh_pkg::status_type status,
   output shabsh_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PAD   = 6'b000010,
      ST_LOAD  = 6'b000100,
      ST_ROUND = 6'b001000,
      ST_ADD   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   logic [5:0] round_ff;
   logic [5:0] round_in;
   logic [2:0] widx_ff;
   logic [2:0] widx_in;
   logic       end_pend_ff;
   logic       end_pend_in;
   logic       pad_act_ff;
   logic       pad_act_in;
   logic       pad_first_ff;
   logic       pad_first_in;
   logic       len_ok_ff;
   logic       len_ok_in;
   logic       final_ff;
   logic       final_in;

   shabsh_pkg::byte_sel_type pad_sel;

   always_comb begin
      if (pad_first_ff) begin
         pad_sel = shabsh_pkg::SEL_PAD80;
      end else if (len_ok_ff && (status.fill >= shabsh_pkg::LEN_START)) begin
         pad_sel = shabsh_pkg::SEL_LEN;
      end else begin
         pad_sel = shabsh_pkg::SEL_ZERO;
      end
   end

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      widx_in      = widx_ff;
      end_pend_in  = end_pend_ff;
      pad_act_in   = pad_act_ff;
      pad_first_in = pad_first_ff;
      len_ok_in    = len_ok_ff;
      final_in     = final_ff;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      cmd            = '0;
      cmd.byte_sel   = shabsh_pkg::SEL_DATA;
      cmd.round_idx  = round_ff;
      cmd.word_idx   = widx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.push       = req_has_byte;
               cmd.count_byte = req_has_byte;
               if (req_has_byte && (status.fill == shabsh_pkg::FILL_LAST)) begin
                  state_in    = ST_LOAD;
                  end_pend_in = req_last;
               end else if (req_last) begin
                  state_in     = ST_PAD;
                  pad_act_in   = 1'b1;
                  pad_first_in = 1'b1;
               end
            end
         end
         ST_PAD: begin
            cmd.push     = 1'b1;
            cmd.byte_sel = pad_sel;
            pad_first_in = 1'b0;
            if (pad_first_ff && (status.fill < shabsh_pkg::LEN_START)) begin
               len_ok_in = 1'b1;
            end
            if (status.fill == shabsh_pkg::FILL_LAST) begin
               state_in = ST_LOAD;
               if (pad_sel == shabsh_pkg::SEL_LEN) begin
                  final_in = 1'b1;
               end else begin
                  len_ok_in = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            cmd.load_work = 1'b1;
            round_in      = 6'd0;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == shabsh_pkg::ROUND_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add_hash = 1'b1;
            if (final_ff) begin
               state_in = ST_EMIT;
               widx_in  = 3'd0;
            end else if (end_pend_ff) begin
               state_in     = ST_PAD;
               end_pend_in  = 1'b0;
               pad_act_in   = 1'b1;
               pad_first_in = 1'b1;
            end else if (pad_act_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == shabsh_pkg::WORD_LAST) begin
                  cmd.restart = 1'b1;
                  state_in    = ST_IDLE;
                  final_in    = 1'b0;
                  len_ok_in   = 1'b0;
                  pad_act_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= 6'd0;
         widx_ff      <= 3'd0;
         end_pend_ff  <= 1'b0;
         pad_act_ff   <= 1'b0;
         pad_first_ff <= 1'b0;
         len_ok_ff    <= 1'b0;
         final_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         widx_ff      <= widx_in;
         end_pend_ff  <= end_pend_in;
         pad_act_ff   <= pad_act_in;
         pad_first_ff <= pad_first_in;
         len_ok_ff    <= len_ok_in;
         final_ff     <= final_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("result offered while input open");

   a_full_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> ($past(round_ff) == shabsh_pkg::ROUND_LAST))
      else $error("hash update before last round");

   a_final_has_len: assert property (@(posedge clock) disable iff (reset)
      final_ff |-> len_ok_ff)
      else $error("final block without length field");

   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && rsp_tready && (widx_ff == shabsh_pkg::WORD_LAST))
      |=> ((state_ff == ST_IDLE) && !final_ff && !pad_act_ff))
      else $error("digest end did not restart message");

endmodule

`default_nettype wire

/* rtl/sha256_byte_stream_hasher_top.sv */
`default_nettype none

// Channel   Dir  tdata                 tuser               tlast
// req_      in   [7:0] data_byte       [0] has_byte        end_of_message
// rsp_      out  [31:0] digest_word    [2:0] word_index    last_word
//
// An item that neither completes a block nor ends the message leaves req_tready high;
// the 64th byte of a block holds req_tready low through the load, the 64 rounds of
// the single round unit and the add. End of message: padding bytes complete the block
// and each final block (one or two) is compressed, then eight digest transactions follow.
// Reset is synchronous; no clearing pass follows.
// rsp_tready low holds the current digest word; no input is taken until all eight leave.

module sha256_byte_stream_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast
);

   shabsh_pkg::cmd_type    cmd;
   shabsh_pkg::status_type status;

   shabsh_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_has_byte (req_tuser),
      .req_last     (req_tlast),
      .req_tready   (req_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .status       (status),
      .cmd          (cmd)
   );

   shabsh_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_tdata),
      .status      (status),
      .digest_word (rsp_tdata)
   );

   assign rsp_tuser = cmd.word_idx;
   assign rsp_tlast = (cmd.word_idx == shabsh_pkg::WORD_LAST);

endmodule

`default_nettype wire

/* tb/sv/tb_sha256_byte_stream_hasher_top.sv */
`timescale 1ns / 100ps

module tb_sha256_byte_stream_hasher_top;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 200;
   localparam int ITEM_TARGET = 170;
   localparam int NUM_DIRECTED = 12;

   localparam logic [255:0] EMPTY_DIGEST =
      256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

   typedef struct packed {
      logic [7:0]   data;
      logic         has;
      logic         eom;
      logic         typed;
      logic [255:0] digest;
   } hash_step_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  idx;
      logic        last;
   } digest_beat_type;

   localparam hash_step_type DIRECTED [NUM_DIRECTED] = '{
      '{8'h00, 1'b0, 1'b0, 1'b0, 256'd0},
      '{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
      '{8'h61, 1'b1, 1'b0, 1'b0, 256'd0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 256'd0},
      '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
      '{8'h00, 1'b1, 1'b0, 1'b0, 256'd0},
      '{8'hff, 1'b0, 1'b0, 1'b0, 256'd0},
      '{8'hff, 1'b1, 1'b0, 1'b0, 256'd0},
      '{8'h5a, 1'b0, 1'b1, 1'b0, 256'd0},
      '{8'hff, 1'b1, 1'b1, 1'b0, 256'd0},
      '{8'h00, 1'b1, 1'b1, 1'b0, 256'd0},
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}
   };

   localparam int BOUNDARY_LEN [8] = '{0, 55, 56, 57, 63, 64, 65, 120};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   logic [31:0] chain_words [8];
   logic [7:0]  block_bytes [64];
   int unsigned block_fill;
   logic [63:0] byte_total;

   digest_beat_type digest_due [$];
   int           fault_count;
   int           cycle_count;
   int           items_sent;
   logic         req_calm;
   logic         rsp_calm;

   sha256_byte_stream_hasher_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_sha256_byte_stream_hasher_top: errors");
         $finish;
      end
   end

   function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
      return (v >> s) | (v << (32 - s));
   endfunction

   function automatic void reset_chain();
      for (int i = 0; i < 8; i++) chain_words[i] = shabsh_pkg::H_INIT[i];
      block_fill = 0;
      byte_total = 64'd0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 16; t++)
         w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      for (int t = 16; t < 64; t++) begin
         s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      a = chain_words[0]; b = chain_words[1]; c = chain_words[2]; d = chain_words[3];
      e = chain_words[4]; f = chain_words[5]; g = chain_words[6]; h = chain_words[7];
      for (int t = 0; t < 64; t++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
              + shabsh_pkg::K_TABLE[t] + w[t];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_words[0] += a; chain_words[1] += b; chain_words[2] += c; chain_words[3] += d;
      chain_words[4] += e; chain_words[5] += f; chain_words[6] += g; chain_words[7] += h;
   endfunction

   function automatic void hash_item(input logic [7:0] data, input logic has, input logic eom,
                                     output logic done, output logic [255:0] digest);
      logic [63:0] bit_len;
      done = 1'b0;
      digest = 256'd0;
      if (has) begin
         block_bytes[block_fill] = data;
         block_fill++;
         byte_total++;
         if (block_fill == 64) begin
            compress_block();
            block_fill = 0;
         end
      end
      if (!eom) return;
      bit_len = byte_total << 3;
      block_bytes[block_fill] = 8'h80;
      block_fill++;
      if (block_fill > 56) begin
         while (block_fill < 64) block_bytes[block_fill++] = 8'h00;
         compress_block();
         block_fill = 0;
      end
      while (block_fill < 56) block_bytes[block_fill++] = 8'h00;
      for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) digest[255-32*i -: 32] = chain_words[i];
      done = 1'b1;
      reset_chain();
   endfunction

   task automatic send_item(input logic [7:0] data, input logic has, input logic eom,
                            input logic typed, input logic [255:0] typed_digest);
      int          gap;
      logic        done;
      logic [255:0] digest;
      digest_beat_type beat;
      gap = req_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= has;
      req_tlast  <= eom;
      do @(posedge clock); while (!req_tready);
      hash_item(data, has, eom, done, digest);
      if (done) begin
         if (typed) digest = typed_digest;
         for (int i = 0; i < 8; i++) begin
            beat = '{digest[255-32*i -: 32], 3'(i), i == 7};
            digest_due = {digest_due, beat};
         end
      end
      items_sent++;
   endtask

   task automatic send_message(input int len);
      logic ride;
      ride = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 256'd0);
         send_item(8'($urandom_range(0, 255)), 1'b1, ride && (i == len - 1), 1'b0, 256'd0);
      end
      if (!ride)
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 256'd0);
   endtask

   initial begin
      digest_beat_type got, want;
      rsp_tready <= 1'b0;
      rsp_calm = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         int gap;
         gap = rsp_calm ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = '{rsp_tdata, rsp_tuser, rsp_tlast};
         if (digest_due.size() == 0) begin
            if (fault_count < 10)
               $display("unexpected digest transaction: word %h index %0d last %b",
                        got.word, got.idx, got.last);
            fault_count++;
         end else begin
            want = digest_due.pop_front();
            if (got !== want) begin
               if (fault_count < 10)
                  $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                           want.word, want.idx, want.last, got.word, got.idx, got.last);
               fault_count++;
            end
         end
         if ($urandom_range(0, 15) == 0) rsp_calm = ~rsp_calm;
      end
   end

   initial begin
      int len;
      cycle_count = 0;
      fault_count = 0;
      items_sent  = 0;
      req_calm    = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      reset_chain();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_item(DIRECTED[i].data, DIRECTED[i].has, DIRECTED[i].eom,
                   DIRECTED[i].typed, DIRECTED[i].digest);

      while (items_sent < ITEM_TARGET) begin
         req_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 4)
            len = BOUNDARY_LEN[$urandom_range(0, 7)];
         else
            len = $urandom_range(0, 20);
         if (len > ITEM_TARGET - items_sent)
            len = ITEM_TARGET - items_sent;
         send_message(len);
      end
      req_tvalid <= 1'b0;

      while (digest_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("tb_sha256_byte_stream_hasher_top: clean");
      else
         $display("tb_sha256_byte_stream_hasher_top: errors");
      $finish;
   end

endmodule
